// ===== hdl/uvs_pkg.sv =====
// shared types, constants and the cordic arctangent table for the uv sphere generator
package uvs_pkg;

  localparam int unsigned CordicSteps = 20;
  localparam int unsigned AngW = 32;
  localparam int unsigned QW = 34;
  localparam logic signed [QW-1:0] CordicGain = 34'sd652032874;

  localparam logic [1:0] CfgRadius = 2'd0;
  localparam logic [1:0] CfgStack  = 2'd1;
  localparam logic [1:0] CfgSlice  = 2'd2;

  // per-item side data carried along the pipeline
  typedef struct packed {
    logic        quad_valid;
    logic [20:0] top_index;
    logic [20:0] bottom_index;
    logic [15:0] radius;
  } side_t;

  // arctangent of 2^-i in 2^-32 turn units
  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] r;
    begin
      case (i)
        5'd0: r = 32'd536870912;
        5'd1: r = 32'd316933406;
        5'd2: r = 32'd167458907;
        5'd3: r = 32'd85004756;
        5'd4: r = 32'd42667331;
        5'd5: r = 32'd21354465;
        5'd6: r = 32'd10679838;
        5'd7: r = 32'd5340245;
        5'd8: r = 32'd2670163;
        5'd9: r = 32'd1335087;
        5'd10: r = 32'd667544;
        5'd11: r = 32'd333772;
        5'd12: r = 32'd166886;
        5'd13: r = 32'd83443;
        5'd14: r = 32'd41722;
        5'd15: r = 32'd20861;
        5'd16: r = 32'd10430;
        5'd17: r = 32'd5215;
        5'd18: r = 32'd2608;
        5'd19: r = 32'd1304;
        default: r = 32'd0;
      endcase
      return r;
    end
  endfunction

endpackage

// ===== hdl/uvs_div_cell.sv =====
// one restoring division cell: produces one quotient bit per stage
module uvs_div_cell #(
  parameter int unsigned NW = 43,
  parameter int unsigned DW = 11,
  parameter int unsigned BIT = 0
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [DW:0]   rem_i,
  output logic [NW-1:0] num_o,
  output logic [DW-1:0] den_o,
  output logic [DW:0]   rem_o
);

  logic [DW+1:0] trial;
  logic [DW:0]   rem_d, rem_q;
  logic [NW-1:0] num_d, num_q;
  logic [DW-1:0] den_q;

  // shift in the next numerator bit and try subtracting the divisor
  always_comb begin
    trial = {rem_i, num_i[BIT]};
    num_d = num_i;
    if (trial >= {2'b00, den_i}) begin
      rem_d = (DW+1)'(trial - {2'b00, den_i});
      num_d[BIT] = 1'b1;
    end else begin
      rem_d = trial[DW:0];
      num_d[BIT] = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      num_q <= num_d;
      den_q <= den_i;
    end
  end

  assign num_o = num_q;
  assign den_o = den_q;
  assign rem_o = rem_q;

endmodule

// ===== hdl/uvs_divider.sv =====
// pipelined divider built from a row of one-bit cells
module uvs_divider #(
  parameter int unsigned NW = 43,
  parameter int unsigned DW = 11
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [NW-1:0] quo_o
);

  logic [NW-1:0] num_s [NW+1];
  logic [DW-1:0] den_s [NW+1];
  logic [DW:0]   rem_s [NW+1];

  assign num_s[0] = num_i;
  assign den_s[0] = den_i;
  assign rem_s[0] = '0;

  // quotient bits replace numerator bits msb first
  for (genvar g = 0; g < NW; g++) begin : g_cell
    uvs_div_cell #(.NW(NW), .DW(DW), .BIT(NW-1-g)) u_cell (
      .clk_i (clk_i),
      .en_i  (en_i),
      .num_i (num_s[g]),
      .den_i (den_s[g]),
      .rem_i (rem_s[g]),
      .num_o (num_s[g+1]),
      .den_o (den_s[g+1]),
      .rem_o (rem_s[g+1])
    );
  end

  assign quo_o = num_s[NW];

endmodule

// ===== hdl/uvs_cordic_cell.sv =====
// one cordic rotation cell with registered outputs
module uvs_cordic_cell #(
  parameter int unsigned STEP = 0
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic signed [uvs_pkg::QW-1:0] x_i,
  input  logic signed [uvs_pkg::QW-1:0] y_i,
  input  logic signed [uvs_pkg::QW-1:0] z_i,
  output logic signed [uvs_pkg::QW-1:0] x_o,
  output logic signed [uvs_pkg::QW-1:0] y_o,
  output logic signed [uvs_pkg::QW-1:0] z_o
);

  localparam logic signed [uvs_pkg::QW-1:0] Atan =
    uvs_pkg::QW'(uvs_pkg::atan_turn(5'(STEP)));

  logic signed [uvs_pkg::QW-1:0] dx, dy;
  logic signed [uvs_pkg::QW-1:0] x_d, y_d, z_d, x_q, y_q, z_q;

  // arithmetic shift is a floor
  always_comb begin
    dx = y_i >>> STEP;
    dy = x_i >>> STEP;
    if (!z_i[uvs_pkg::QW-1]) begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - Atan;
    end else begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + Atan;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;

endmodule

// ===== hdl/uvs_cordic.sv =====
// sine and cosine of a turn angle through a row of cordic cells
module uvs_cordic (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [uvs_pkg::AngW-1:0]      ang_i,
  output logic signed [uvs_pkg::QW-1:0] cos_o,
  output logic signed [uvs_pkg::QW-1:0] sin_o
);

  localparam int unsigned N = uvs_pkg::CordicSteps;

  logic signed [uvs_pkg::QW-1:0] xs [N+1];
  logic signed [uvs_pkg::QW-1:0] ys [N+1];
  logic signed [uvs_pkg::QW-1:0] zs [N+1];
  logic [1:0] quad_q [N];

  assign xs[0] = uvs_pkg::CordicGain;
  assign ys[0] = '0;
  assign zs[0] = {4'b0000, ang_i[29:0]};

  for (genvar g = 0; g < N; g++) begin : g_cell
    uvs_cordic_cell #(.STEP(g)) u_cell (
      .clk_i (clk_i),
      .en_i  (en_i),
      .x_i   (xs[g]),
      .y_i   (ys[g]),
      .z_i   (zs[g]),
      .x_o   (xs[g+1]),
      .y_o   (ys[g+1]),
      .z_o   (zs[g+1])
    );
  end

  // quadrant travels alongside the rotation
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quad_q[0] <= ang_i[31:30];
      for (int i = 1; i < N; i++) quad_q[i] <= quad_q[i-1];
    end
  end

  // map back to the full circle
  always_comb begin
    case (quad_q[N-1])
      2'd0: begin cos_o = xs[N];  sin_o = ys[N];  end
      2'd1: begin cos_o = -ys[N]; sin_o = xs[N];  end
      2'd2: begin cos_o = -xs[N]; sin_o = -ys[N]; end
      default: begin cos_o = ys[N]; sin_o = -xs[N]; end
    endcase
  end

endmodule

// ===== hdl/uv_sphere_vertex_generator_top.sv =====
// top level of the uv sphere vertex generator
// Usage: each transfer on the input channel (in_valid_i/in_ready_o, row_i,
// col_i) gives one transfer on the output channel (out_valid_o/out_ready_i)
// with position, normal, texture coordinates and quad indices.
// Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i;
// index 0 radius, 1 stack count, 2 slice count, other indexes are ignored.
// Write configuration only while no item is in flight.
// Throughput: one item per cycle while the receiver does not stall.
// Stages: the input stage, the 43-cell bit-per-stage divider for the angles,
// the 20-cell cordic row, the product stage and the rounding and output stage.
// The whole pipeline advances only when the output register is free or
// being emptied, so a stalled receiver holds every stage in place and
// in_ready_o falls together with the stall.
// Reset clears all valid flags and loads radius 1.0 and 16 by 16 divisions.
module uv_sphere_vertex_generator_top #(
  parameter int unsigned MAX_DIVISIONS = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [10:0]        row_i,
  input  logic [10:0]        col_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [16:0] pos_x_o,
  output logic signed [16:0] pos_y_o,
  output logic signed [16:0] pos_z_o,
  output logic signed [15:0] norm_x_o,
  output logic signed [15:0] norm_y_o,
  output logic signed [15:0] norm_z_o,
  output logic [16:0]        tex_u_o,
  output logic [16:0]        tex_v_o,
  output logic               quad_valid_o,
  output logic [20:0]        quad_top_index_o,
  output logic [20:0]        quad_bottom_index_o
);

  localparam int unsigned NW = 43;
  localparam int unsigned DW = 13;
  localparam int unsigned DIVL = NW;
  localparam int unsigned CORL = uvs_pkg::CordicSteps;
  localparam int unsigned LAT = 1 + DIVL + CORL + 2;
  localparam logic [12:0] MaxDiv = 13'(MAX_DIVISIONS);

  logic [15:0] radius_q;
  logic [10:0] stack_q, slice_q;
  logic adv;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= 16'd256;
      stack_q  <= 11'd16;
      slice_q  <= 11'd16;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        uvs_pkg::CfgRadius: radius_q <= cfg_data_i;
        uvs_pkg::CfgStack:  stack_q  <= cfg_data_i[10:0];
        uvs_pkg::CfgSlice:  slice_q  <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  // valid flags along the pipeline, last stage is the output register
  logic [LAT-1:0] vld_q;
  assign out_valid_o = vld_q[LAT-1];
  assign adv = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (adv) vld_q <= {vld_q[LAT-2:0], in_valid_i};
  end

  // stage 0: effective counts, saturation, indices
  logic [12:0] st, sl, r, c;
  logic qv;
  logic [23:0] top;
  always_comb begin
    st = (stack_q == '0) ? 13'd1 : ((13'(stack_q) > MaxDiv) ? MaxDiv : 13'(stack_q));
    sl = (slice_q == '0) ? 13'd1 : ((13'(slice_q) > MaxDiv) ? MaxDiv : 13'(slice_q));
    r = (13'(row_i) > st) ? st : 13'(row_i);
    c = (13'(col_i) > sl) ? sl : 13'(col_i);
    qv = (13'(row_i) < st) && (13'(col_i) < sl);
    top = 24'(row_i) * 24'(sl + 13'd1) + 24'(col_i);
  end

  logic [NW-1:0] th_num_q, ph_num_q, u_num_q, v_num_q;
  logic [DW-1:0] sl_q0, st_q0;
  uvs_pkg::side_t side0_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      th_num_q <= (NW'(c) << 32) + NW'(sl >> 1);
      ph_num_q <= (NW'(r) << 31) + NW'(st >> 1);
      u_num_q  <= (NW'(c) << 16) + NW'(sl >> 1);
      v_num_q  <= (NW'(r) << 16) + NW'(st >> 1);
      sl_q0 <= sl;
      st_q0 <= st;
      side0_q.quad_valid   <= qv;
      side0_q.top_index    <= qv ? top[20:0] : 21'd0;
      side0_q.bottom_index <= qv ? 21'(top + 24'(sl) + 24'd1) : 21'd0;
      side0_q.radius       <= radius_q;
    end
  end

  logic [NW-1:0] th_quo, ph_quo, u_quo, v_quo;
  uvs_divider #(.NW(NW), .DW(DW)) u_div_th (
    .clk_i(clk_i), .en_i(adv), .num_i(th_num_q), .den_i(sl_q0), .quo_o(th_quo));
  uvs_divider #(.NW(NW), .DW(DW)) u_div_ph (
    .clk_i(clk_i), .en_i(adv), .num_i(ph_num_q), .den_i(st_q0), .quo_o(ph_quo));
  uvs_divider #(.NW(NW), .DW(DW)) u_div_u (
    .clk_i(clk_i), .en_i(adv), .num_i(u_num_q), .den_i(sl_q0), .quo_o(u_quo));
  uvs_divider #(.NW(NW), .DW(DW)) u_div_v (
    .clk_i(clk_i), .en_i(adv), .num_i(v_num_q), .den_i(st_q0), .quo_o(v_quo));

  // side data delay line matching the dividers and the cordic
  uvs_pkg::side_t side_dl [DIVL+CORL];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_dl[0] <= side0_q;
      for (int i = 1; i < DIVL + CORL; i++) side_dl[i] <= side_dl[i-1];
    end
  end

  // texture coordinates wait for the cordic
  logic [16:0] u_dl [CORL];
  logic [16:0] v_dl [CORL];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      u_dl[0] <= u_quo[16:0];
      v_dl[0] <= v_quo[16:0];
      for (int i = 1; i < CORL; i++) begin
        u_dl[i] <= u_dl[i-1];
        v_dl[i] <= v_dl[i-1];
      end
    end
  end

  logic signed [uvs_pkg::QW-1:0] cp, sp, ct, stt;
  uvs_cordic u_cor_ph (
    .clk_i(clk_i), .en_i(adv), .ang_i(ph_quo[31:0]), .cos_o(cp), .sin_o(sp));
  uvs_cordic u_cor_th (
    .clk_i(clk_i), .en_i(adv), .ang_i(th_quo[31:0]), .cos_o(ct), .sin_o(stt));

  // product stage: normals in q4.30
  logic signed [63:0] px, pz;
  logic signed [33:0] nx_q, ny_q, nz_q;
  logic [16:0] u1_q, v1_q;
  uvs_pkg::side_t side1_q;
  always_comb begin
    px = 64'(sp) * 64'(ct) + 64'sd536870912;
    pz = 64'(sp) * 64'(stt) + 64'sd536870912;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      nx_q <= 34'(px >>> 30);
      nz_q <= 34'(pz >>> 30);
      ny_q <= cp;
      u1_q <= u_dl[CORL-1];
      v1_q <= v_dl[CORL-1];
      side1_q <= side_dl[DIVL+CORL-1];
    end
  end

  // output stage: scaling, rounding and clamping
  function automatic logic [16:0] pos_of(input logic signed [33:0] q, input logic [15:0] rad);
    logic signed [51:0] p;
    logic signed [51:0] s;
    begin
      p = 52'(q) * $signed({36'd0, rad}) + 52'sd536870912;
      s = p >>> 30;
      if (s < -52'sd65536) return 17'h10000;
      if (s > 52'sd65535) return 17'h0ffff;
      return s[16:0];
    end
  endfunction

  function automatic logic [15:0] norm_of(input logic signed [33:0] q);
    logic signed [33:0] s;
    begin
      s = (q + 34'sd32768) >>> 16;
      if (s < -34'sd16384) return 16'hc000;
      if (s > 34'sd16384) return 16'h4000;
      return s[15:0];
    end
  endfunction

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pos_x_o  <= pos_of(nx_q, side1_q.radius);
      pos_y_o  <= pos_of(ny_q, side1_q.radius);
      pos_z_o  <= pos_of(nz_q, side1_q.radius);
      norm_x_o <= norm_of(nx_q);
      norm_y_o <= norm_of(ny_q);
      norm_z_o <= norm_of(nz_q);
      tex_u_o  <= u1_q;
      tex_v_o  <= v1_q;
      quad_valid_o        <= side1_q.quad_valid;
      quad_top_index_o    <= side1_q.top_index;
      quad_bottom_index_o <= side1_q.bottom_index;
    end
  end

endmodule

// ===== sim/uv_sphere_vertex_generator_checker.sv =====
// channel monitor, vertex predictor and result comparison for the uv sphere generator
module uv_sphere_vertex_generator_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [10:0]        row_i,
  input  logic [10:0]        col_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic signed [16:0] pos_x_i,
  input  logic signed [16:0] pos_y_i,
  input  logic signed [16:0] pos_z_i,
  input  logic signed [15:0] norm_x_i,
  input  logic signed [15:0] norm_y_i,
  input  logic signed [15:0] norm_z_i,
  input  logic [16:0]        tex_u_i,
  input  logic [16:0]        tex_v_i,
  input  logic               quad_valid_i,
  input  logic [20:0]        quad_top_index_i,
  input  logic [20:0]        quad_bottom_index_i,
  output int                 mismatch_count_o,
  output int                 vertices_pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint MaxDiv = 1024;
  localparam longint Gain = 652032874;

  typedef struct packed {
    logic [16:0] pos_x;
    logic [16:0] pos_y;
    logic [16:0] pos_z;
    logic [15:0] norm_x;
    logic [15:0] norm_y;
    logic [15:0] norm_z;
    logic [16:0] tex_u;
    logic [16:0] tex_v;
    logic        quad_valid;
    logic [20:0] top_index;
    logic [20:0] bottom_index;
  } vertex_t;

  // arctangent of 2^-i in 2^-32 turn units
  longint arctan_turns [20] = '{
    536870912, 316933406, 167458907, 85004756, 42667331,
    21354465, 10679838, 5340245, 2670163, 1335087,
    667544, 333772, 166886, 83443, 41722,
    20861, 10430, 5215, 2608, 1304
  };

  longint radius_q88;
  longint stacks_raw;
  longint slices_raw;
  vertex_t vertex_q[$];
  int mismatches;

  assign mismatch_count_o   = mismatches;
  assign vertices_pending_o = vertex_q.size();

  function automatic longint clamp_count(longint v);
    if (v == 0) return 1;
    return (v > MaxDiv) ? MaxDiv : v;
  endfunction

  function automatic longint rnd_shift(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // rotation in the first quadrant, then mapped onto the full turn
  task automatic turn_sincos(input longint angle, output longint co, output longint si);
    longint x, y, z, dx, dy;
    x = Gain;
    y = 0;
    z = angle & 64'h3FFF_FFFF;
    for (int i = 0; i < 20; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= arctan_turns[i];
      end else begin
        x += dx; y -= dy; z += arctan_turns[i];
      end
    end
    case ((angle >> 30) & 3)
      0: begin co = x;  si = y;  end
      1: begin co = -y; si = x;  end
      2: begin co = -x; si = -y; end
      default: begin co = y; si = -x; end
    endcase
  endtask

  function automatic logic [16:0] position(longint q30);
    return 17'(clamp(rnd_shift(radius_q88 * q30, 30), -65536, 65535));
  endfunction

  function automatic logic [15:0] normal(longint q30);
    return 16'(clamp(rnd_shift(q30, 16), -16384, 16384));
  endfunction

  task automatic predict_vertex(input longint row, input longint col, output vertex_t v);
    longint st, sl, r, c, theta, phi, cp, sp, ct, stt, nx, nz, top;
    st = clamp_count(stacks_raw);
    sl = clamp_count(slices_raw);
    r = (row > st) ? st : row;
    c = (col > sl) ? sl : col;
    theta = (((c << 32) + sl / 2) / sl) & 64'hFFFF_FFFF;
    phi = ((r << 31) + st / 2) / st;
    turn_sincos(phi, cp, sp);
    turn_sincos(theta, ct, stt);
    nx = rnd_shift(sp * ct, 30);
    nz = rnd_shift(sp * stt, 30);
    v.pos_x = position(nx);
    v.pos_y = position(cp);
    v.pos_z = position(nz);
    v.norm_x = normal(nx);
    v.norm_y = normal(cp);
    v.norm_z = normal(nz);
    v.tex_u = 17'((c * 65536 + sl / 2) / sl);
    v.tex_v = 17'((r * 65536 + st / 2) / st);
    v.quad_valid = (row < st) && (col < sl);
    top = row * (sl + 1) + col;
    v.top_index = v.quad_valid ? 21'(top) : '0;
    v.bottom_index = v.quad_valid ? 21'(top + sl + 1) : '0;
  endtask

  task automatic compare_field(string name, longint want, longint got);
    if (want != got) begin
      mismatches++;
      $display("%0t: mismatch on %s, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  // register writes, input transfers and output transfers
  always @(posedge clk_i or negedge rst_ni) begin
    vertex_t v;
    if (!rst_ni) begin
      radius_q88 <= 256;
      stacks_raw <= 16;
      slices_raw <= 16;
      vertex_q.delete();
      mismatches = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (vertex_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected output transfer, expected none, got row result %0h",
                   $time, tex_v_i);
        end else begin
          v = vertex_q.pop_front();
          compare_field("pos_x", v.pos_x, $unsigned(pos_x_i));
          compare_field("pos_y", v.pos_y, $unsigned(pos_y_i));
          compare_field("pos_z", v.pos_z, $unsigned(pos_z_i));
          compare_field("norm_x", v.norm_x, $unsigned(norm_x_i));
          compare_field("norm_y", v.norm_y, $unsigned(norm_y_i));
          compare_field("norm_z", v.norm_z, $unsigned(norm_z_i));
          compare_field("tex_u", v.tex_u, tex_u_i);
          compare_field("tex_v", v.tex_v, tex_v_i);
          compare_field("quad_valid", v.quad_valid, quad_valid_i);
          compare_field("quad_top_index", v.top_index, quad_top_index_i);
          compare_field("quad_bottom_index", v.bottom_index, quad_bottom_index_i);
        end
      end
      if (in_valid_i && in_ready_i) begin
        predict_vertex(row_i, col_i, v);
        vertex_q.insert(vertex_q.size(), v);
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          uvs_pkg::CfgRadius: radius_q88 <= cfg_data_i;
          uvs_pkg::CfgStack:  stacks_raw <= cfg_data_i & 16'h07FF;
          uvs_pkg::CfgSlice:  slices_raw <= cfg_data_i & 16'h07FF;
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== sim/uv_sphere_vertex_generator_top_tb.sv =====
// stimulus and verdict for the uv sphere vertex generator
module uv_sphere_vertex_generator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // an index that maps to no register
  localparam logic [1:0] CfgUnused = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i = uvs_pkg::CfgRadius;
  logic [15:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [10:0] row_i = '0;
  logic [10:0] col_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b1;
  logic signed [16:0] pos_x_o, pos_y_o, pos_z_o;
  logic signed [15:0] norm_x_o, norm_y_o, norm_z_o;
  logic [16:0] tex_u_o, tex_v_o;
  logic quad_valid_o;
  logic [20:0] quad_top_index_o, quad_bottom_index_o;
  int mismatch_count;
  int vertices_pending;

  bit calm = 1'b0;
  bit long_hold = 1'b0;
  int stacks_eff = 16;
  int slices_eff = 16;

  uv_sphere_vertex_generator_top DUT (.*);

  uv_sphere_vertex_generator_checker u_checker (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .row_i, .col_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .pos_x_i(pos_x_o), .pos_y_i(pos_y_o), .pos_z_i(pos_z_o),
    .norm_x_i(norm_x_o), .norm_y_i(norm_y_o), .norm_z_i(norm_z_o),
    .tex_u_i(tex_u_o), .tex_v_i(tex_v_o), .quad_valid_i(quad_valid_o),
    .quad_top_index_i(quad_top_index_o), .quad_bottom_index_i(quad_bottom_index_o),
    .mismatch_count_o(mismatch_count), .vertices_pending_o(vertices_pending)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #5ms;
    $display("*** FAILED ***");
    $finish;
  end

  // receiver side: random stall bursts, one long hold on request
  always begin
    if (long_hold) begin
      out_ready_i <= 1'b0;
      repeat (400) @(posedge clk_i);
      out_ready_i <= 1'b1;
      long_hold = 1'b0;
      @(posedge clk_i);
    end else if (!calm && rst_ni && $urandom_range(0, 3) == 0) begin
      out_ready_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk_i);
    end else begin
      @(posedge clk_i);
    end
  end

  task automatic send_point(input int row, input int col);
    in_valid_i <= 1'b1;
    row_i <= 11'(row);
    col_i <= 11'(col);
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic sender_gap();
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
  endtask

  // drain every result, then leave the pipeline time to go quiet
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (vertices_pending != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    int n;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    n = data & 16'h07FF;
    n = (n == 0) ? 1 : ((n > 1024) ? 1024 : n);
    if (idx == uvs_pkg::CfgStack) stacks_eff = n;
    if (idx == uvs_pkg::CfgSlice) slices_eff = n;
    @(posedge clk_i);
  endtask

  task automatic configure(input logic [15:0] rad, input logic [15:0] st,
                           input logic [15:0] sl);
    write_reg(uvs_pkg::CfgRadius, rad);
    write_reg(uvs_pkg::CfgStack, st);
    write_reg(uvs_pkg::CfgSlice, sl);
    @(posedge clk_i);
  endtask

  // mostly on-grid points, some just past the edge, some anywhere
  task automatic random_points(input int count);
    int r, c, k;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(0, 9);
      if (k < 8) begin
        r = $urandom_range(0, stacks_eff);
        c = $urandom_range(0, slices_eff);
      end else if (k == 8) begin
        r = $urandom_range(stacks_eff, stacks_eff + 3);
        c = $urandom_range(slices_eff, slices_eff + 3);
      end else begin
        r = $urandom_range(0, 2047);
        c = $urandom_range(0, 2047);
      end
      sender_gap();
      send_point(r, c);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: corners, edges, past the grid
    send_point(0, 0);     send_point(16, 16);  send_point(0, 16);
    send_point(16, 0);    send_point(8, 4);    send_point(15, 15);
    send_point(17, 17);   send_point(2047, 2047);
    send_point(4, 12);    send_point(12, 4);
    random_points(300);
    drain();

    // largest radius and counts, with a long receiver hold
    configure(16'hFFFF, 16'd1024, 16'd1024);
    send_point(1024, 1024); send_point(1023, 1023); send_point(512, 256);
    send_point(0, 1024);    send_point(2047, 0);    send_point(1, 1);
    long_hold = 1'b1;
    random_points(320);
    drain();

    // zero radius and zero counts; a write to an unused index is ignored
    configure(16'h0000, 16'h0000, 16'h0000);
    write_reg(CfgUnused, 16'hFFFF);
    send_point(0, 0); send_point(1, 1); send_point(0, 1); send_point(2047, 2047);
    random_points(300);
    drain();

    // counts above the limit
    configure(16'd12345, 16'hFFFF, 16'd1100);
    random_points(320);
    drain();

    // small odd counts, random radius
    configure(16'($urandom), 16'd3, 16'd7);
    random_points(320);
    drain();

    // final stretch with no idling on either side
    calm = 1'b1;
    configure(16'd256, 16'd1, 16'd2);
    send_point(0, 0); send_point(1, 2); send_point(0, 1);
    random_points(300);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (vertices_pending != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/uvs_pkg.sv
hdl/uvs_div_cell.sv
hdl/uvs_divider.sv
hdl/uvs_cordic_cell.sv
hdl/uvs_cordic.sv
hdl/uv_sphere_vertex_generator_top.sv
sim/uv_sphere_vertex_generator_checker.sv
sim/uv_sphere_vertex_generator_top_tb.sv
